[hw/rtl/vn2d_pkg.sv]
package vn2d_pkg;

  localparam int unsigned FRAC_BITS_DEF      = 16;
  localparam int unsigned COS_TABLE_BITS_DEF = 10;

  // Lattice hash constants.
  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

  // Constants for building the cosine weight table.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned TAYLOR_TERMS = 10;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // Weight (1 - cos(pi*t)) / 2 in Q0.16 for t = i / 2^ctb, evaluated at elaboration.
  function automatic logic [15:0] wtab_entry(input int unsigned i, input int unsigned ctb);
    logic [63:0]        u;
    logic [63:0]        theta;
    logic [63:0]        q;
    logic [63:0]        term;
    logic signed [63:0] c;
    logic signed [63:0] d;
    logic               flip;
    logic [63:0]        sz;
    sz   = 64'd1 << ctb;
    u    = 64'(i);
    flip = 1'b0;
    if ((64'(i) << 1) > sz) begin
      u    = sz - 64'(i);
      flip = 1'b1;
    end
    theta = (PI_Q30 * u) >> ctb;
    q     = (theta * theta) >> 30;
    c     = 64'sd1073741824;
    term  = 64'd1073741824;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = ((term * q) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 0) begin
        c = c - $signed(term);
      end else begin
        c = c + $signed(term);
      end
    end
    d = flip ? (64'sd1073741824 + c) : (64'sd1073741824 - c);
    if (d < 0) begin
      d = 64'sd0;
    end
    d = (d + 64'sd16384) >>> 15;
    if (d > 64'sd65535) begin
      d = 64'sd65535;
    end
    return d[15:0];
  endfunction

endpackage

[hw/rtl/value_noise_2d.sv]
// Throughput: one transaction per cycle while the output is not stalled; nine register stages carry the hash
// multiplier chain, the 3x3 smoothing sums and the two cosine blends.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers keep no reset.
module value_noise_2d
  import vn2d_pkg::*;
#(
  parameter int unsigned FRAC_BITS      = FRAC_BITS_DEF,
  parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_x_int,
  input  logic [15:0]        in_x_frac,
  input  logic [15:0]        in_y_int,
  input  logic [15:0]        in_y_frac,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_noise_value
);

  localparam int unsigned WTAB_SIZE = 1 << COS_TABLE_BITS;
  localparam int unsigned NSTAGE    = 9;
  // The fraction is taken to a table index by a fixed shift one way or the other.
  localparam int unsigned SH_R = (FRAC_BITS >= COS_TABLE_BITS) ? FRAC_BITS - COS_TABLE_BITS : 0;
  localparam int unsigned SH_L = (FRAC_BITS >= COS_TABLE_BITS) ? 0 : COS_TABLE_BITS - FRAC_BITS;
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  // The weight table is a read-only memory whose contents are fixed at elaboration.
  logic [15:0] wtab_rom [WTAB_SIZE];
  for (genvar gi = 0; gi < WTAB_SIZE; gi++) begin : g_wtab
    assign wtab_rom[gi] = wtab_entry(gi, COS_TABLE_BITS);
  end

  // The whole pipeline advances together unless the output holds an untaken result.
  logic                     advance;
  logic [NSTAGE:1]          vld_r;

  assign out_valid = vld_r[NSTAGE];
  assign advance   = !vld_r[NSTAGE] || !out_stall;
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NSTAGE-1:1], in_valid};
    end
  end

  // Table index from a fraction.
  logic [COS_TABLE_BITS-1:0] xidx;
  logic [COS_TABLE_BITS-1:0] yidx;
  logic [63:0]               xf64;
  logic [63:0]               yf64;
  logic [63:0]               xsh;
  logic [63:0]               ysh;

  assign xf64 = 64'(in_x_frac) & FRAC_MASK;
  assign yf64 = 64'(in_y_frac) & FRAC_MASK;
  assign xsh  = (xf64 >> SH_R) << SH_L;
  assign ysh  = (yf64 >> SH_R) << SH_L;
  assign xidx = xsh[COS_TABLE_BITS-1:0];
  assign yidx = ysh[COS_TABLE_BITS-1:0];

  // Stage 1: hash seeds for the 4x4 lattice around the point, and the weight reads.
  // Grid entry [a][b] is lattice point (x_int + a - 1, y_int + b - 1).
  logic [31:0] n_nxt [4][4];
  logic [31:0] n1_r  [4][4];
  logic [15:0] wx1_r, wy1_r;

  always_comb begin
    logic [31:0] xc;
    logic [31:0] yc;
    logic [31:0] nb;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        xc = 32'(in_x_int) + 32'(a) - 32'd1;
        yc = 32'(in_y_int) + 32'(b) - 32'd1;
        nb = xc + yc * HASH_Y_MUL;
        n_nxt[a][b] = (nb << 13) ^ nb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      n1_r  <= n_nxt;
      wx1_r <= wtab_rom[xidx];
      wy1_r <= wtab_rom[yidx];
    end
  end

  // Stage 2: square. Stage 3: second factor. Stage 4: final product and mapping to Q2.30.
  logic [31:0]        sq2_r [4][4];
  logic [31:0]        n2_r  [4][4];
  logic [31:0]        t3_r  [4][4];
  logic [31:0]        n3_r  [4][4];
  logic signed [31:0] h4_r  [4][4];
  logic [15:0]        wx2_r, wy2_r, wx3_r, wy3_r, wx4_r, wy4_r;

  always_ff @(posedge clk) begin
    logic [31:0]        m;
    logic signed [32:0] hv;
    if (advance) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          sq2_r[a][b] <= 32'(n1_r[a][b] * n1_r[a][b]);
          n2_r[a][b]  <= n1_r[a][b];
          t3_r[a][b]  <= 32'(sq2_r[a][b] * HASH_C1) + HASH_C2;
          n3_r[a][b]  <= n2_r[a][b];
          m           = (32'(n3_r[a][b] * t3_r[a][b]) + HASH_C3) & HASH_MASK;
          hv          = ONE_Q30 - $signed({1'b0, m});
          h4_r[a][b]  <= hv[31:0];
        end
      end
      wx2_r <= wx1_r;
      wy2_r <= wy1_r;
      wx3_r <= wx2_r;
      wy3_r <= wy2_r;
      wx4_r <= wx3_r;
      wy4_r <= wy3_r;
    end
  end

  // Stage 5: 3x3 weighted sums for the four corners, times 16.
  // Corner [cx][cy] is centered on grid entry [cx+1][cy+1].
  logic signed [35:0] s5_r [2][2];
  logic [15:0]        wx5_r, wy5_r;

  always_ff @(posedge clk) begin
    logic signed [35:0] crn;
    logic signed [35:0] sid;
    logic signed [35:0] ctr;
    if (advance) begin
      for (int cx = 0; cx < 2; cx++) begin
        for (int cy = 0; cy < 2; cy++) begin
          crn = 36'(h4_r[cx][cy]) + 36'(h4_r[cx+2][cy])
              + 36'(h4_r[cx][cy+2]) + 36'(h4_r[cx+2][cy+2]);
          sid = 36'(h4_r[cx][cy+1]) + 36'(h4_r[cx+2][cy+1])
              + 36'(h4_r[cx+1][cy]) + 36'(h4_r[cx+1][cy+2]);
          ctr = 36'(h4_r[cx+1][cy+1]);
          s5_r[cx][cy] <= crn + (sid <<< 1) + (ctr <<< 2);
        end
      end
      wx5_r <= wx4_r;
      wy5_r <= wy4_r;
    end
  end

  // Stage 6: divide by 16 (floor) and form the x-direction blend products.
  logic signed [31:0] v1, v2, v3, v4;
  logic signed [35:0] v1w, v2w, v3w, v4w;
  logic signed [32:0] dx1, dx2;
  logic signed [49:0] px1_r, px2_r;
  logic signed [31:0] v1_6_r, v3_6_r;
  logic [15:0]        wy6_r;

  assign v1w = s5_r[0][0] >>> 4;
  assign v2w = s5_r[1][0] >>> 4;
  assign v3w = s5_r[0][1] >>> 4;
  assign v4w = s5_r[1][1] >>> 4;
  assign v1  = v1w[31:0];
  assign v2  = v2w[31:0];
  assign v3  = v3w[31:0];
  assign v4  = v4w[31:0];
  assign dx1 = 33'(v2) - 33'(v1);
  assign dx2 = 33'(v4) - 33'(v3);

  always_ff @(posedge clk) begin
    if (advance) begin
      px1_r  <= 50'(dx1) * $signed({34'd0, wx5_r});
      px2_r  <= 50'(dx2) * $signed({34'd0, wx5_r});
      v1_6_r <= v1;
      v3_6_r <= v3;
      wy6_r  <= wy5_r;
    end
  end

  // Stage 7: finish the x blends.
  logic signed [49:0] i1w, i2w;
  logic signed [31:0] i1_7_r, i2_7_r;
  logic [15:0]        wy7_r;

  assign i1w = 50'(v1_6_r) + (px1_r >>> 16);
  assign i2w = 50'(v3_6_r) + (px2_r >>> 16);

  always_ff @(posedge clk) begin
    if (advance) begin
      i1_7_r <= i1w[31:0];
      i2_7_r <= i2w[31:0];
      wy7_r  <= wy6_r;
    end
  end

  // Stage 8: y blend product. Stage 9: finish the y blend into the output register.
  logic signed [32:0] dy;
  logic signed [49:0] py8_r;
  logic signed [31:0] i1_8_r;
  logic signed [49:0] rw;
  logic signed [31:0] res_r;

  assign dy = 33'(i2_7_r) - 33'(i1_7_r);
  assign rw = 50'(i1_8_r) + (py8_r >>> 16);

  always_ff @(posedge clk) begin
    if (advance) begin
      py8_r  <= 50'(dy) * $signed({34'd0, wy7_r});
      i1_8_r <= i1_7_r;
      res_r  <= rw[31:0];
    end
  end

  assign out_noise_value = res_r;

`ifndef SYNTHESIS
  // Input is held back exactly when a result waits at the output.
  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output hold");

  // Nothing moves inside the pipeline while it is held.
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline valid bits changed during a hold");

  // An accepted transaction enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted transaction lost at entry");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
